@@ hdl/kvt_pkg.sv @@
// Package for the key/value table: sizes, action codes and controller states.
`timescale 1ns / 1ps

package kvt_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 9;
  localparam int ACT_W       = 3;
  localparam int IN_IDX_W    = 8;
  localparam int OUT_CNT_W   = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_UPDATE = 3'd1,
    ACT_UPSERT = 3'd2,
    ACT_ERASE  = 3'd3,
    ACT_LOOKUP = 3'd4,
    ACT_READ   = 3'd5
  } kvt_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_APPLY,
    ST_DONE
  } kvt_state_t;

endpackage

@@ hdl/kvt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module kvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/key_value_table_core.sv @@
// Key/value table: linear-search map of unique keys held in two RAMs.
//
// Usage: an item enters on the in_ channel (action, key, value, index) when
// in_valid and in_ready are both high. Each item gives exactly one result on
// the out_ channel (out_ok, out_key, out_value, out_entry_count), held in an
// output register until out_valid and out_ready are both high.
// Keyed actions scan the stored entries one per cycle through the key RAM
// read port, then the execute, (if needed) apply and result steps follow;
// read by index skips the scan, unused codes go straight to the result step.
// One item is in work at a time; the next is taken once the previous result
// sits in the output register, even if the receiver has not yet taken it. A
// stalled receiver only holds the block when a second result is ready while
// the first still waits. The capacity register is written through cfg_ while
// the block is idle; the user is bound to this, the block does not enforce it.
// Synchronous reset (rst_n low) empties the table and sets the capacity to
// 256; the RAM contents are left as they are and never read before written.
`timescale 1ns / 1ps

module key_value_table_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kvt_pkg::ACT_W-1:0]     in_action,
  input  logic [kvt_pkg::DATA_W-1:0]    in_key,
  input  logic [kvt_pkg::DATA_W-1:0]    in_value,
  input  logic [kvt_pkg::IN_IDX_W-1:0]  in_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ok,
  output logic [kvt_pkg::DATA_W-1:0]    out_key,
  output logic [kvt_pkg::DATA_W-1:0]    out_value,
  output logic [kvt_pkg::OUT_CNT_W-1:0] out_entry_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kvt_pkg::CAP_W-1:0]     cfg_data
);

  localparam int IDX_W  = kvt_pkg::IDX_W;
  localparam int CNT_W  = kvt_pkg::CNT_W;
  localparam int DATA_W = kvt_pkg::DATA_W;

  kvt_pkg::kvt_state_t state_r, state_nxt;

  logic [kvt_pkg::CAP_W-1:0]     cap_r;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [kvt_pkg::ACT_W-1:0]     act_r, act_nxt;
  logic [DATA_W-1:0]             key_r, key_nxt;
  logic [DATA_W-1:0]             val_r, val_nxt;
  logic [CNT_W-1:0]              scan_r, scan_nxt;
  logic                          cmp_valid_r, cmp_valid_nxt;
  logic [IDX_W-1:0]              cmp_pos_r, cmp_pos_nxt;
  logic [IDX_W-1:0]              pos_r, pos_nxt;
  logic                          found_r, found_nxt;
  logic                          res_ok_r, res_ok_nxt;
  logic [DATA_W-1:0]             res_key_r, res_key_nxt;
  logic [DATA_W-1:0]             res_val_r, res_val_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_ok_r, out_ok_nxt;
  logic [DATA_W-1:0]             out_key_r, out_key_nxt;
  logic [DATA_W-1:0]             out_val_r, out_val_nxt;
  logic [kvt_pkg::OUT_CNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic              key_we, val_we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [DATA_W-1:0] key_wdata, val_wdata;
  logic [DATA_W-1:0] key_rd, val_rd;
  logic              room;
  logic [CNT_W-1:0]  cnt_m1;

  kvt_ram #(.WIDTH(DATA_W), .DEPTH(kvt_pkg::MAX_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rd)
  );

  kvt_ram #(.WIDTH(DATA_W), .DEPTH(kvt_pkg::MAX_ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (waddr),
    .wdata (val_wdata),
    .raddr (raddr),
    .rdata (val_rd)
  );

  // Room for one more pair under both the configured and the physical limit.
  assign room = (32'(cnt_r) < 32'(cap_r)) && (32'(cnt_r) < 32'(kvt_pkg::MAX_ENTRIES));
  assign cnt_m1 = cnt_r - CNT_W'(1);

  assign in_ready        = (state_r == kvt_pkg::ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_key         = out_key_r;
  assign out_value       = out_val_r;
  assign out_entry_count = out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kvt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= kvt_pkg::CAP_RESET;
      cnt_r       <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      cnt_r       <= cnt_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    scan_r    <= scan_nxt;
    cmp_pos_r <= cmp_pos_nxt;
    pos_r     <= pos_nxt;
    found_r   <= found_nxt;
    res_ok_r  <= res_ok_nxt;
    res_key_r <= res_key_nxt;
    res_val_r <= res_val_nxt;
    out_ok_r  <= out_ok_nxt;
    out_key_r <= out_key_nxt;
    out_val_r <= out_val_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    act_nxt       = act_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    scan_nxt      = scan_r;
    cmp_valid_nxt = cmp_valid_r;
    cmp_pos_nxt   = cmp_pos_r;
    pos_nxt       = pos_r;
    found_nxt     = found_r;
    res_ok_nxt    = res_ok_r;
    res_key_nxt   = res_key_r;
    res_val_nxt   = res_val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ok_nxt    = out_ok_r;
    out_key_nxt   = out_key_r;
    out_val_nxt   = out_val_r;
    out_cnt_nxt   = out_cnt_r;
    key_we        = 1'b0;
    val_we        = 1'b0;
    waddr         = pos_r;
    key_wdata     = key_r;
    val_wdata     = val_r;
    raddr         = scan_r[IDX_W-1:0];

    case (state_r)
      kvt_pkg::ST_IDLE: begin
        if (in_valid) begin
          act_nxt       = in_action;
          key_nxt       = in_key;
          val_nxt       = in_value;
          res_ok_nxt    = 1'b0;
          res_key_nxt   = '0;
          res_val_nxt   = '0;
          scan_nxt      = '0;
          cmp_valid_nxt = 1'b0;
          found_nxt     = 1'b0;
          pos_nxt       = IDX_W'(in_index);
          if (in_action == kvt_pkg::ACT_READ) begin
            found_nxt = (32'(in_index) < 32'(cnt_r));
            state_nxt = kvt_pkg::ST_EXEC;
          end else if (in_action == kvt_pkg::ACT_INSERT || in_action == kvt_pkg::ACT_UPDATE ||
                       in_action == kvt_pkg::ACT_UPSERT || in_action == kvt_pkg::ACT_ERASE ||
                       in_action == kvt_pkg::ACT_LOOKUP) begin
            state_nxt = kvt_pkg::ST_SCAN;
          end else begin
            state_nxt = kvt_pkg::ST_DONE;
          end
        end
      end

      // One read issued and one compare done per cycle; the compare lags the
      // read by the RAM latency.
      kvt_pkg::ST_SCAN: begin
        if (cmp_valid_r && key_rd == key_r) begin
          found_nxt     = 1'b1;
          pos_nxt       = cmp_pos_r;
          cmp_valid_nxt = 1'b0;
          state_nxt     = kvt_pkg::ST_EXEC;
        end else if (!cmp_valid_r && scan_r >= cnt_r) begin
          found_nxt = 1'b0;
          state_nxt = kvt_pkg::ST_EXEC;
        end else begin
          cmp_valid_nxt = (scan_r < cnt_r);
          cmp_pos_nxt   = scan_r[IDX_W-1:0];
          if (scan_r < cnt_r) begin
            scan_nxt = scan_r + CNT_W'(1);
          end
        end
      end

      kvt_pkg::ST_EXEC: begin
        state_nxt = kvt_pkg::ST_DONE;
        case (act_r)
          kvt_pkg::ACT_INSERT, kvt_pkg::ACT_UPSERT: begin
            if (found_r && act_r == kvt_pkg::ACT_UPSERT) begin
              val_we     = 1'b1;
              res_ok_nxt = 1'b1;
            end else if (!found_r && room) begin
              waddr      = cnt_r[IDX_W-1:0];
              key_we     = 1'b1;
              val_we     = 1'b1;
              cnt_nxt    = cnt_r + CNT_W'(1);
              res_ok_nxt = 1'b1;
            end
          end
          kvt_pkg::ACT_UPDATE: begin
            if (found_r) begin
              val_we     = 1'b1;
              res_ok_nxt = 1'b1;
            end
          end
          kvt_pkg::ACT_ERASE: begin
            // Fetch the last pair to move it into the freed slot.
            if (found_r) begin
              raddr     = cnt_m1[IDX_W-1:0];
              state_nxt = kvt_pkg::ST_APPLY;
            end
          end
          kvt_pkg::ACT_LOOKUP, kvt_pkg::ACT_READ: begin
            if (found_r) begin
              raddr     = pos_r;
              state_nxt = kvt_pkg::ST_APPLY;
            end
          end
          default: begin
          end
        endcase
      end

      kvt_pkg::ST_APPLY: begin
        state_nxt  = kvt_pkg::ST_DONE;
        res_ok_nxt = 1'b1;
        case (act_r)
          kvt_pkg::ACT_ERASE: begin
            key_we    = 1'b1;
            val_we    = 1'b1;
            key_wdata = key_rd;
            val_wdata = val_rd;
            cnt_nxt   = cnt_m1;
          end
          kvt_pkg::ACT_LOOKUP: begin
            res_val_nxt = val_rd;
          end
          kvt_pkg::ACT_READ: begin
            res_key_nxt = key_rd;
            res_val_nxt = val_rd;
          end
          default: begin
            res_ok_nxt = 1'b0;
          end
        endcase
      end

      kvt_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_key_nxt   = res_key_r;
          out_val_nxt   = res_val_r;
          out_cnt_nxt   = kvt_pkg::OUT_CNT_W'(cnt_r);
          state_nxt     = kvt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = kvt_pkg::ST_IDLE;
      end
    endcase
  end

  // The entry count moves only when a pair is appended or erased.
  a_cnt_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != kvt_pkg::ST_EXEC && state_r != kvt_pkg::ST_APPLY) |=> $stable(cnt_r))
    else $error("entry count changed outside the apply steps");

  // An append never goes past the configured or physical capacity.
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kvt_pkg::ST_EXEC && key_we) |-> room)
    else $error("pair appended to a full table");

  // The scan compares only stored positions.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kvt_pkg::ST_SCAN && cmp_valid_r) |-> (32'(cmp_pos_r) < 32'(cnt_r)))
    else $error("scan compared a position past the entry count");

  // A new result is loaded only from the result step.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && (!out_valid_r || out_ready)) |-> (state_r == kvt_pkg::ST_DONE))
    else $error("result loaded outside the result step");

endmodule
